// ----- rtl/safety_switch_arming_sequencer_assert.svh -----
// Assertion macros for the safety switch arming sequencer.
// Each macro expects signals named clk and rst in the scope that uses it.
`ifndef SAFETY_SWITCH_ARMING_SEQUENCER_ASSERT_SVH
`define SAFETY_SWITCH_ARMING_SEQUENCER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SSAS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sequencer check failed: invariant");

// A condition that must hold in the cycle after a trigger.
`define SSAS_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("sequencer check failed: next-cycle implication");

`endif

// ----- rtl/ssas_pkg.sv -----
// Shared types and constants for the safety switch arming sequencer.
// Used by the configuration bank, the step core and the top level.
package ssas_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE         = 3'd0;
  localparam logic [2:0] REG_PRESS_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_FRAME_KIND     = 3'd2;
  localparam logic [2:0] REG_REFUSE_PATTERN = 3'd3;
  localparam logic [2:0] REG_INIT_PATTERN   = 3'd4;
  localparam logic [2:0] REG_SAFE_PATTERN   = 3'd5;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [11:0] PRESS_THRESHOLD_RST = 12'd512;

  // Frame kinds.
  localparam logic [1:0] FRAME_MULTIROTOR = 2'd0;
  localparam logic [1:0] FRAME_AIRPLANE   = 2'd1;

  // Phase window limits and blink counter wrap.
  localparam logic [7:0] LIM_FIRST  = 8'd30;
  localparam logic [7:0] LIM_SECOND = 8'd60;
  localparam logic [7:0] LIM_RESET  = 8'd150;
  localparam logic [5:0] BLINK_LAST = 6'd45;

  // Beep codes.
  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_INIT = 2'd1;
  localparam logic [1:0] BEEP_SAFE = 2'd2;
  localparam logic [1:0] BEEP_FAIL = 2'd3;

  // Motor action codes.
  localparam logic [1:0] MOTOR_NONE     = 2'd0;
  localparam logic [1:0] MOTOR_MIN      = 2'd1;
  localparam logic [1:0] MOTOR_DISABLED = 2'd2;

  // LED pattern selection.
  localparam logic [1:0] PSEL_ZERO   = 2'd0;
  localparam logic [1:0] PSEL_REFUSE = 2'd1;
  localparam logic [1:0] PSEL_INIT   = 2'd2;
  localparam logic [1:0] PSEL_SAFE   = 2'd3;

  typedef struct packed {
    logic        enable;
    logic [11:0] press_threshold;
    logic [1:0]  frame_kind;
    logic [15:0] refuse_pattern;
    logic [15:0] init_pattern;
    logic [15:0] safe_pattern;
  } cfg_t;

  // Packed so that led_on lands in the lowest bit.
  typedef struct packed {
    logic       safe_to_output;
    logic [1:0] motor_action;
    logic [1:0] beep_code;
    logic       led_on;
  } result_t;

  // Counters exposed for checking.
  typedef struct packed {
    logic [7:0] phase_count;
    logic [5:0] blink_count;
  } status_t;

endpackage

// ----- rtl/safety_switch_arming_sequencer.sv -----
// Top level of the safety switch arming sequencer: stream ports, input and
// result registers. Depends on ssas_pkg, ssas_cfg, ssas_core and the assert header.

// The block takes one item per clock and gives one result per item: each
// item is held in the input register, then steps through the sequencer
// logic into the result register. A waiting result does not stop the next
// item from entering the input register; throughput drops only while the
// result register stays full and m_tready is low. The sequencer state
// (phase counter, flags, blink counter, last tick time) is updated once per
// item at the edge that loads its result. Configuration writes take effect
// at once and are meant to be made while no item is in flight.
`include "safety_switch_arming_sequencer_assert.svh"

module safety_switch_arming_sequencer
  import ssas_pkg::*;
#(
  parameter int unsigned TICK_INTERVAL_MS = 33,
  parameter int unsigned COUNT_MAX        = 255
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [31:0] time_ms, [43:32] button_sample, [44] armed, [47:45] zero
  input  logic [47:0]            s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] led_on, [2:1] beep_code, [4:3] motor_action, [5] safe_to_output,
  // [7:6] zero
  output logic [7:0]             m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  result_t     core_result;
  status_t     status;

  logic        in_valid;
  logic [31:0] in_time;
  logic [11:0] in_sample;
  logic        in_armed;
  logic        advance;
  result_t     out_result;

  ssas_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssas_core #(
    .TICK_INTERVAL_MS (TICK_INTERVAL_MS),
    .COUNT_MAX        (COUNT_MAX)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (advance),
    .time_ms       (in_time),
    .button_sample (in_sample),
    .armed         (in_armed),
    .result        (core_result),
    .status        (status)
  );

  // The held item moves on whenever the result register is free or drains.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_time   <= s_tdata[31:0];
      in_sample <= s_tdata[43:32];
      in_armed  <= s_tdata[44];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tdata = {2'b00, out_result};

  // Checks on the pipeline control and the counters.
  `SSAS_ASSERT_NEXT(a_step_loads_result, advance, m_tvalid)
  `SSAS_ASSERT_ALWAYS(a_stall_only_when_full, s_tready || (in_valid && m_tvalid && !m_tready))
  `SSAS_ASSERT_ALWAYS(a_phase_ceiling, status.phase_count <= 8'(COUNT_MAX))
  `SSAS_ASSERT_ALWAYS(a_blink_range, status.blink_count <= BLINK_LAST)

endmodule

// ----- rtl/ssas_cfg.sv -----
// Configuration register bank of the safety switch arming sequencer.
// Depends on ssas_pkg for register indexes and the cfg_t bundle.
module ssas_cfg
  import ssas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b1;
      cfg.press_threshold <= PRESS_THRESHOLD_RST;
      cfg.frame_kind      <= FRAME_MULTIROTOR;
      cfg.refuse_pattern  <= '0;
      cfg.init_pattern    <= '0;
      cfg.safe_pattern    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:          cfg.enable          <= cfg_data[0];
        REG_PRESS_THRESHOLD: cfg.press_threshold <= cfg_data[11:0];
        REG_FRAME_KIND:      cfg.frame_kind      <= cfg_data[1:0];
        REG_REFUSE_PATTERN:  cfg.refuse_pattern  <= cfg_data;
        REG_INIT_PATTERN:    cfg.init_pattern    <= cfg_data;
        REG_SAFE_PATTERN:    cfg.safe_pattern    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/ssas_core.sv -----
// Sequencer state and the combinational step for one input item.
// Depends on ssas_pkg; the top level supplies the registered item and step strobe.
module ssas_core
  import ssas_pkg::*;
#(
  parameter int unsigned TICK_INTERVAL_MS = 33,
  parameter int unsigned COUNT_MAX        = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        step,
  input  logic [31:0] time_ms,
  input  logic [11:0] button_sample,
  input  logic        armed,
  output result_t     result,
  output status_t     status
);

  localparam logic [31:0] TICK_W   = 32'(TICK_INTERVAL_MS);
  localparam logic [7:0]  CMAX     = 8'(COUNT_MAX);
  localparam logic [7:0]  CREWIND  = 8'(COUNT_MAX - 2);

  logic [7:0]  phase_count, phase_count_next;
  logic        wait_flag, wait_flag_next;
  logic        safe_flag, safe_flag_next;
  logic [1:0]  pattern_select, pattern_select_next;
  logic [5:0]  blink_count, blink_count_next;
  logic [31:0] last_tick_time, last_tick_time_next;
  logic        led_level, led_level_next;

  logic        pressed;
  logic        run;
  logic [31:0] elapsed;
  logic [1:0]  beep;
  logic [1:0]  motor;
  logic        motor_allowed;
  logic [15:0] pattern;
  logic [11:0] blink_x43;
  logic [4:0]  bit_idx;
  logic [5:0]  blink_inc;
  logic        wait_mid;

  assign pressed       = button_sample <= cfg.press_threshold;
  assign elapsed       = time_ms - last_tick_time;
  assign motor_allowed = (cfg.frame_kind == FRAME_MULTIROTOR) ||
                         (cfg.frame_kind == FRAME_AIRPLANE);
  // Blink counter divided by 3: multiply by 43/128, exact below 64.
  assign blink_x43     = 12'(blink_count) * 12'd43;
  assign bit_idx       = blink_x43[11:7];
  assign blink_inc     = blink_count + 6'd1;

  // Next-state logic for one item.
  always_comb begin
    phase_count_next    = phase_count;
    wait_flag_next      = wait_flag;
    safe_flag_next      = safe_flag;
    pattern_select_next = pattern_select;
    blink_count_next    = blink_count;
    last_tick_time_next = last_tick_time;
    led_level_next      = led_level;
    beep                = BEEP_NONE;
    motor               = MOTOR_NONE;
    run                 = 1'b0;
    pattern             = '0;
    wait_mid            = wait_flag;

    // Tick gating: the time stamp moves even while armed.
    if (cfg.enable && (elapsed >= TICK_W)) begin
      last_tick_time_next = time_ms;
      run                 = !armed;
    end

    if (run) begin
      // Window handling on the count held before this tick.
      if (phase_count < LIM_FIRST) begin
        pattern_select_next = PSEL_REFUSE;
      end else if (phase_count > LIM_FIRST && phase_count < LIM_SECOND) begin
        pattern_select_next = PSEL_INIT;
        if (phase_count == LIM_FIRST + 8'd1) begin
          beep = BEEP_INIT;
        end
        if (pressed) begin
          wait_flag_next = 1'b1;
          motor          = motor_allowed ? MOTOR_MIN : MOTOR_NONE;
        end else if (!wait_flag) begin
          phase_count_next = LIM_FIRST + 8'd1;
        end
      end else if (phase_count > LIM_SECOND && phase_count < LIM_RESET) begin
        pattern_select_next = PSEL_SAFE;
        if (phase_count == LIM_SECOND + 8'd1) begin
          beep     = BEEP_SAFE;
          wait_mid = 1'b0;
        end
        wait_flag_next = wait_mid;
        if (pressed) begin
          wait_flag_next = 1'b1;
          safe_flag_next = 1'b1;
        end else if (!wait_mid) begin
          phase_count_next = LIM_SECOND + 8'd1;
        end
      end else if (phase_count > LIM_RESET) begin
        if (phase_count == LIM_RESET + 8'd1) begin
          beep           = BEEP_FAIL;
          wait_flag_next = 1'b0;
        end else if (pressed) begin
          phase_count_next = '0;
          motor            = motor_allowed ? MOTOR_DISABLED : MOTOR_NONE;
          safe_flag_next   = 1'b0;
        end else begin
          phase_count_next = CREWIND;
        end
      end

      // LED bit from the window's pattern word.
      case (pattern_select_next)
        PSEL_REFUSE: pattern = cfg.refuse_pattern;
        PSEL_INIT:   pattern = cfg.init_pattern;
        PSEL_SAFE:   pattern = cfg.safe_pattern;
        default:     pattern = '0;
      endcase
      led_level_next   = (bit_idx < 5'd16) ? pattern[bit_idx[3:0]] : 1'b0;
      blink_count_next = (blink_inc > BLINK_LAST) ? 6'd0 : blink_inc;

      // A released button advances the counter up to its ceiling.
      if (!pressed && (phase_count_next < CMAX)) begin
        phase_count_next = phase_count_next + 8'd1;
      end
    end
  end

  // State update once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count    <= '0;
      wait_flag      <= 1'b0;
      safe_flag      <= 1'b0;
      pattern_select <= PSEL_ZERO;
      blink_count    <= '0;
      last_tick_time <= '0;
      led_level      <= 1'b0;
    end else if (step) begin
      phase_count    <= phase_count_next;
      wait_flag      <= wait_flag_next;
      safe_flag      <= safe_flag_next;
      pattern_select <= pattern_select_next;
      blink_count    <= blink_count_next;
      last_tick_time <= last_tick_time_next;
      led_level      <= led_level_next;
    end
  end

  assign result.led_on         = led_level_next;
  assign result.beep_code      = beep;
  assign result.motor_action   = motor;
  assign result.safe_to_output = cfg.enable ? safe_flag_next : 1'b1;

  assign status.phase_count = phase_count;
  assign status.blink_count = blink_count;

endmodule
